>>> rtl/assert_macros.svh
// Assertion helpers used by adhp_back; all are clocked on clk and idle during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ADHP_ASSERT_COMB(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequence holds in the same cycle
`define ADHP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the next cycle
`define ADHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/adhp_pkg.sv
package adhp_pkg;

    localparam int SMP_W     = 15;
    localparam int WORD_W    = 16;
    localparam int LOOKAHEAD = 3;
    localparam int WIN_DEPTH = LOOKAHEAD + 1;
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
    localparam int LEN_W     = 4;

    localparam logic [LEN_W-1:0]  LEN_RUN    = 4'd1;
    localparam logic [LEN_W-1:0]  LEN_ZERO   = 4'd2;
    localparam logic [3:0]        PTR_TOP    = 4'd15;
    localparam logic [WORD_W-1:0] EMPTY_WORD = 16'h8000;
    localparam logic [WORD_W-1:0] NEG_FLAG   = 16'h4000;
    localparam int                SMALL_MAX  = 3;

    localparam logic MODE_PASS    = 1'b0;
    localparam logic MODE_PACK    = 1'b1;
    localparam logic REG_IDX_MODE = 1'b0;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_FIRST,
        KIND_NORM
    } kind_t;

    // one sample as seen by the packer
    typedef struct packed {
        logic [WORD_W-1:0] word;      // raw form, or sign-extended sample
        logic [LEN_W-1:0]  code_len;  // prefix code length of the difference
        logic              raw;       // difference too large for a code
    } elem_t;

    typedef struct packed {
        kind_t kind;
        elem_t elem;
        logic  last;
    } entry_t;

endpackage

>>> rtl/adhp_front.sv
module adhp_front import adhp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 coding_mode,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [WORD_W-1:0]    s_axis_tdata,   // [14:0] sample
    input  logic                 s_axis_tlast,
    output logic                 push_valid,
    output entry_t               push_entry,
    input  logic                 push_ready
);

    logic signed [WORD_W-1:0] prev_reg, prev_next;
    logic                     first_reg, first_next;

    logic signed [WORD_W-1:0] smp_ext;
    logic signed [WORD_W-1:0] diff;
    logic        [WORD_W-1:0] neg_diff;
    logic        [WORD_W-1:0] neg_smp;
    logic        [WORD_W-1:0] raw_word;
    logic        [LEN_W-1:0]  code_len;
    logic                     fits_code;
    logic                     accept;

    assign smp_ext   = {s_axis_tdata[SMP_W-1], s_axis_tdata[SMP_W-1:0]};
    assign diff      = smp_ext - prev_reg;
    assign neg_diff  = WORD_W'(-diff);
    assign neg_smp   = WORD_W'(-smp_ext);
    assign fits_code = (diff <= WORD_W'(SMALL_MAX)) && (diff >= -WORD_W'(SMALL_MAX));

    // zero and negative samples carry the sign in bit 14
    assign raw_word = (smp_ext > 0) ? WORD_W'(unsigned'(smp_ext)) : (neg_smp | NEG_FLAG);

    always_comb
    begin
        if (diff == '0)
            code_len = LEN_ZERO;
        else if (!diff[WORD_W-1])
            code_len = {diff[2:0], 1'b1};
        else
            code_len = {neg_diff[2:0] + 3'd1, 1'b0};
    end

    always_comb
    begin
        if (coding_mode == MODE_PASS)
            push_entry.kind = KIND_PASS;
        else if (first_reg)
            push_entry.kind = KIND_FIRST;
        else
            push_entry.kind = KIND_NORM;
        push_entry.elem.word     = (push_entry.kind == KIND_NORM) ? raw_word
                                                                   : unsigned'(smp_ext);
        push_entry.elem.code_len = code_len;
        push_entry.elem.raw      = !fits_code;
        push_entry.last          = s_axis_tlast;
    end

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;
    assign accept        = s_axis_tvalid && push_ready;

    always_comb
    begin
        prev_next  = prev_reg;
        first_next = first_reg;
        if (accept && coding_mode == MODE_PACK)
        begin
            prev_next  = smp_ext;
            first_next = s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            prev_reg  <= prev_next;
            first_reg <= first_next;
        end
    end

endmodule

>>> rtl/adhp_fifo.sv
module adhp_fifo import adhp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    input  entry_t push_entry,
    output logic   push_ready,
    output logic   pop_valid,
    output entry_t pop_entry,
    input  logic   pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int FCW   = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FCW-1:0]     fill_reg, fill_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (fill_reg != FCW'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        fill_next = fill_reg + FCW'(do_push) - FCW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

>>> rtl/adhp_back.sv
`include "assert_macros.svh"

module adhp_back import adhp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    input  entry_t            pop_entry,
    output logic              pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [WORD_W-1:0] m_axis_tdata,   // [15:0] packed_word
    output logic              m_axis_tlast
);

    // lookahead window: slot 0 is the oldest sample not yet coded
    elem_t              win_reg [WIN_DEPTH];
    elem_t              win_next [WIN_DEPTH];
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               last_pend_reg, last_pend_next;
    logic [WORD_W-1:0]  pack_reg, pack_next;
    logic [3:0]         bptr_reg, bptr_next;
    logic               ov_reg, ov_next;
    logic [WORD_W-1:0]  od_reg, od_next;
    logic               ol_reg, ol_next;

    logic [WIN_DEPTH-1:0] zero_vec;
    logic               head_zero;
    logic               run4;
    logic               tok;
    logic               fin;
    logic               oslot;
    logic [LEN_W-1:0]   len;
    logic [3:0]         bptr_sub;
    logic               emit;
    logic [WORD_W-1:0]  emit_word;
    logic               emit_last;
    logic [CNT_W-1:0]   ncons;
    logic [CNT_W-1:0]   cnt_rem;
    logic               absorb;
    logic               take;

    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
            zero_vec[i] = !win_reg[i].raw && (win_reg[i].code_len == LEN_ZERO);
    end

    assign head_zero = zero_vec[0];
    assign run4      = (cnt_reg == CNT_W'(WIN_DEPTH)) && (&zero_vec);
    assign tok       = (cnt_reg != '0) &&
                       (!head_zero || cnt_reg == CNT_W'(WIN_DEPTH) || last_pend_reg);
    assign fin       = (cnt_reg == '0) && last_pend_reg;
    assign oslot     = !ov_reg || m_axis_tready;
    assign len       = run4 ? LEN_RUN : (head_zero ? LEN_ZERO : win_reg[0].code_len);
    assign bptr_sub  = bptr_reg - len;

    always_comb
    begin
        emit           = 1'b0;
        emit_word      = pack_reg;
        emit_last      = 1'b0;
        ncons          = '0;
        pack_next      = pack_reg;
        bptr_next      = bptr_reg;
        last_pend_next = last_pend_reg;
        take           = 1'b0;
        if (fin)
        begin
            if (oslot)
            begin
                emit           = 1'b1;
                emit_last      = 1'b1;
                pack_next      = EMPTY_WORD;
                bptr_next      = PTR_TOP;
                last_pend_next = 1'b0;
            end
        end
        else if (tok)
        begin
            if (win_reg[0].raw)
            begin
                // a pending word goes out first, the raw value after it
                if (oslot)
                begin
                    emit = 1'b1;
                    if (bptr_reg != PTR_TOP)
                    begin
                        pack_next = EMPTY_WORD;
                        bptr_next = PTR_TOP;
                    end
                    else
                    begin
                        emit_word = win_reg[0].word;
                        ncons     = CNT_W'(1);
                    end
                end
            end
            else if (bptr_reg >= len)
            begin
                bptr_next = bptr_sub;
                pack_next = pack_reg | (WORD_W'(1) << bptr_sub);
                ncons     = run4 ? CNT_W'(WIN_DEPTH) : CNT_W'(1);
            end
            else if (oslot)
            begin
                emit      = 1'b1;
                bptr_next = PTR_TOP - len;
                pack_next = EMPTY_WORD | (WORD_W'(1) << (PTR_TOP - len));
                ncons     = run4 ? CNT_W'(WIN_DEPTH) : CNT_W'(1);
            end
        end
        else if (pop_valid)
        begin
            unique case (pop_entry.kind)
                KIND_PASS:
                begin
                    if (oslot)
                    begin
                        emit      = 1'b1;
                        emit_word = pop_entry.elem.word;
                        emit_last = pop_entry.last;
                        take      = 1'b1;
                    end
                end
                KIND_FIRST:
                begin
                    if (oslot)
                    begin
                        emit           = 1'b1;
                        emit_word      = pop_entry.elem.word;
                        last_pend_next = pop_entry.last;
                        take           = 1'b1;
                    end
                end
                KIND_NORM:
                begin
                end
                default:
                begin
                end
            endcase
        end

        cnt_rem = cnt_reg - ncons;
        absorb  = pop_valid && (pop_entry.kind == KIND_NORM) && !last_pend_reg &&
                  (cnt_rem < CNT_W'(WIN_DEPTH));
        if (absorb)
            last_pend_next = pop_entry.last;
        cnt_next = cnt_rem + CNT_W'(absorb);
    end

    assign pop = absorb || take;

    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            if (ncons == CNT_W'(1) && i < WIN_DEPTH - 1)
                win_next[i] = win_reg[(i + 1) % WIN_DEPTH];
            else
                win_next[i] = win_reg[i];
            if (absorb && cnt_rem == CNT_W'(i))
                win_next[i] = pop_entry.elem;
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        od_next = od_reg;
        ol_next = ol_reg;
        if (emit)
        begin
            ov_next = 1'b1;
            od_next = emit_word;
            ol_next = emit_last;
        end
        else if (m_axis_tready)
        begin
            ov_next = 1'b0;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
        ol_reg <= ol_next;
        for (int i = 0; i < WIN_DEPTH; i++)
            win_reg[i] <= win_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            last_pend_reg <= 1'b0;
            pack_reg      <= EMPTY_WORD;
            bptr_reg      <= PTR_TOP;
            ov_reg        <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            last_pend_reg <= last_pend_next;
            pack_reg      <= pack_next;
            bptr_reg      <= bptr_next;
            ov_reg        <= ov_next;
        end
    end

    `ADHP_ASSERT_COMB(a_cnt_range, cnt_reg <= CNT_W'(WIN_DEPTH), "window overfilled")
    `ADHP_ASSERT_COMB(a_empty_word, (bptr_reg != PTR_TOP) || (pack_reg == EMPTY_WORD),
                      "word marked empty but holds codes")
    `ADHP_ASSERT_IMPL(a_hold_after_last, last_pend_reg, !pop,
                      "next waveform taken before the final word")
    `ADHP_ASSERT_NEXT(a_final_clears, fin && emit,
                      (cnt_reg == '0) && !last_pend_reg && (bptr_reg == PTR_TOP),
                      "packer not back to its start after the final word")

endmodule

>>> rtl/adc_delta_huffman_packer_core.sv
// Delta/prefix-code packer for ADC waveforms.
// Input stream (s_axis): one 15-bit sample per word in tdata[14:0], tlast on the
// final sample of a waveform. Output stream (m_axis): 16-bit words, tlast on the
// final word. Mode register at APB address 0 (bit 0): 1 packs, 0 passes through.
// Throughput: one sample per cycle as long as each sample makes at most one word
// and the receiver does not stall; each further output word slows the input, since
// the output register takes one word per cycle. Held samples resolving on one input
// drain at one code per cycle unless the output stalls; at the end of a waveform
// the window drains before the final word and the next waveform starts only after
// it. A 4-deep queue separates the classifier from the packer, so input is still
// taken while the packer catches up.
// Pass-through and raw first samples pass the queue and the output register; a word
// from coded differences also passes the window and the word being packed.
// Reset puts the packer at the start of a waveform with an empty word and the mode
// register at 1. When the receiver stalls the output register holds its word, the
// packer stops at the next word it must emit, and the input stalls once the queue
// is full. The user changes the mode only with the block idle; it is not enforced.
module adc_delta_huffman_packer_core import adhp_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,   // [14:0] sample, [15] zero
    input  logic              s_axis_tlast,   // sample_last
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [WORD_W-1:0] m_axis_tdata,   // [15:0] packed_word
    output logic              m_axis_tlast,   // word_last
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic   mode_reg, mode_next;
    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   pop_valid;
    logic   pop;
    entry_t pop_entry;

    assign pready = 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_MODE)
            mode_next = pwdata[0];
    end

    assign prdata = (paddr[2] == REG_IDX_MODE) ? {31'b0, mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_PACK;
        else
            mode_reg <= mode_next;
    end

    adhp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .coding_mode   (mode_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (push_valid),
        .push_entry    (push_entry),
        .push_ready    (push_ready)
    );

    adhp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop)
    );

    adhp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_entry     (pop_entry),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> tb/sv/adc_delta_huffman_packer_core_checker.sv
`timescale 1ns / 1ps

module adc_delta_huffman_packer_core_checker import adhp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,   // [14:0] sample, [15] zero
    input  logic              s_axis_tlast,   // sample_last
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [WORD_W-1:0] m_axis_tdata,   // [15:0] packed_word
    input  logic              m_axis_tlast,   // word_last
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                words_pending
);

    localparam logic [2:0] MODE_ADDR = 3'(4 * REG_IDX_MODE);

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } coded_word_t;

    coded_word_t       expected_words[$];

    logic              coding_mode = MODE_PACK;
    int                prev_smp    = 0;
    int                held [0:LOOKAHEAD-1];
    int                held_cnt    = 0;
    logic [WORD_W-1:0] acc_word    = EMPTY_WORD;
    int                bit_ptr     = int'(PTR_TOP);
    logic              first_pend  = 1'b1;

    function void expect_word(input logic [WORD_W-1:0] w, input logic l);
        coded_word_t e;
        e.word = w;
        e.last = l;
        expected_words.push_back(e);
    endfunction

    function void restart_packer();
        prev_smp   = 0;
        held_cnt   = 0;
        acc_word   = EMPTY_WORD;
        bit_ptr    = int'(PTR_TOP);
        first_pend = 1'b1;
    endfunction

    // a code that does not fit flushes the word and opens a fresh one
    function void put_code(input int len);
        if (bit_ptr >= len)
        begin
            bit_ptr           = bit_ptr - len;
            acc_word[bit_ptr] = 1'b1;
        end
        else
        begin
            expect_word(acc_word, 1'b0);
            bit_ptr           = int'(PTR_TOP) - len;
            acc_word          = EMPTY_WORD;
            acc_word[bit_ptr] = 1'b1;
        end
    endfunction

    function void put_raw(input int s);
        logic [WORD_W-1:0] w;
        if (bit_ptr != int'(PTR_TOP))
            expect_word(acc_word, 1'b0);
        acc_word = EMPTY_WORD;
        bit_ptr  = int'(PTR_TOP);
        if (s > 0)
            w = 16'(s);
        else
            w = 16'(-s) | NEG_FLAG;
        expect_word(w, 1'b0);
    endfunction

    function void code_delta(input int d, input int s);
        if (d > SMALL_MAX || d < -SMALL_MAX)
            put_raw(s);
        else if (d == 0)
            put_code(int'(LEN_ZERO));
        else if (d > 0)
            put_code(2 * d + 1);
        else
            put_code(2 - 2 * d);
    endfunction

    function void pack_sample(input logic [SMP_W-1:0] raw, input logic lst);
        int s;
        int n;
        int head;
        int d;
        int prv;
        int win [0:LOOKAHEAD];
        s = int'($signed(raw));
        if (coding_mode == MODE_PASS)
        begin
            expect_word(16'(s), lst);
            return;
        end
        if (first_pend)
        begin
            expect_word(16'(s), 1'b0);
            prev_smp   = s;
            first_pend = 1'b0;
            held_cnt   = 0;
            if (lst)
            begin
                expect_word(acc_word, 1'b1);
                restart_packer();
            end
            return;
        end
        n = held_cnt;
        for (int k = 0; k < n; k++)
            win[k] = held[k];
        win[n] = s;
        n++;
        head = 0;
        while (head < n)
        begin
            prv = (head == 0) ? prev_smp : win[head-1];
            d   = win[head] - prv;
            if (d != 0)
            begin
                code_delta(d, win[head]);
                head++;
            end
            else if (n - head >= LOOKAHEAD + 1)
            begin
                // four equal differences of zero fold into one short code
                if (win[head+1] == win[head] && win[head+2] == win[head+1] &&
                    win[head+3] == win[head+2])
                begin
                    put_code(int'(LEN_RUN));
                    head += 4;
                end
                else
                begin
                    put_code(int'(LEN_ZERO));
                    head++;
                end
            end
            else if (lst)
            begin
                put_code(int'(LEN_ZERO));
                head++;
            end
            else
                break;
        end
        if (head > 0)
            prev_smp = win[head-1];
        held_cnt = n - head;
        for (int k = 0; k < held_cnt; k++)
            held[k] = win[head+k];
        if (lst)
        begin
            expect_word(acc_word, 1'b1);
            restart_packer();
        end
    endfunction

    function void check_word(input logic [WORD_W-1:0] w, input logic l);
        coded_word_t e;
        if (expected_words.size() == 0)
        begin
            $error("packed_word: no word expected, got %h (word_last %b)", w, l);
            fail_count++;
            return;
        end
        e = expected_words.pop_front();
        if (w !== e.word)
        begin
            $error("packed_word: expected %h, got %h", e.word, w);
            fail_count++;
        end
        if (l !== e.last)
        begin
            $error("word_last: expected %b, got %b", e.last, l);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coding_mode = MODE_PACK;
            restart_packer();
            expected_words.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == MODE_ADDR)
                coding_mode = pwdata[0];
            if (m_axis_tvalid && m_axis_tready)
                check_word(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                pack_sample(s_axis_tdata[SMP_W-1:0], s_axis_tlast);
        end
        words_pending = expected_words.size();
    end

endmodule

>>> tb/sv/adc_delta_huffman_packer_core_tb.sv
`timescale 1ns / 1ps

module adc_delta_huffman_packer_core_tb import adhp_pkg::*;
();

    localparam logic [2:0] MODE_ADDR     = 3'(4 * REG_IDX_MODE);
    localparam int         SETTLE_CYCLES = 8;
    localparam int         WDOG_LIMIT    = 2000;
    localparam int         SMP_MIN       = -16384;
    localparam int         SMP_MAX       = 16383;

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [WORD_W-1:0] s_axis_tdata  = '0;   // [14:0] sample, [15] zero
    logic              s_axis_tlast  = 1'b0; // sample_last
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [WORD_W-1:0] m_axis_tdata;         // [15:0] packed_word
    logic              m_axis_tlast;         // word_last
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [2:0]        paddr         = '0;
    logic [31:0]       pwdata        = '0;
    logic [31:0]       prdata;
    logic              pready;

    int                fail_count;
    int                words_pending;
    int                src_idle_pct  = 0;
    int                dst_idle_pct  = 0;
    int                sent_count    = 0;
    int                quiet_cycles  = 0;

    adc_delta_huffman_packer_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    adc_delta_huffman_packer_core_checker packer_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_sample(input int smp, input logic lst);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, 15'(smp)};
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_count++;
    endtask

    // hold off until every predicted word is out, then let held samples settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (words_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= {31'b0, m};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int offset_sample(input int v, input int mag);
        int d;
        int n;
        d = $urandom_range(1) ? mag : -mag;
        n = v + d;
        if (n > SMP_MAX || n < SMP_MIN)
            n = v - d;
        return n;
    endfunction

    function automatic int any_sample();
        return int'($urandom_range(32767)) + SMP_MIN;
    endfunction

    // zero runs, small steps, large jumps and the odd wild value
    task automatic send_waveform(input int len);
        int cur;
        int zrun;
        int r;
        cur  = any_sample();
        zrun = 0;
        for (int i = 0; i < len; i++)
        begin
            if (i > 0)
            begin
                if (zrun > 0)
                    zrun--;
                else
                begin
                    r = $urandom_range(99);
                    if (r < 25)
                        zrun = $urandom_range(6);
                    else if (r < 75)
                        cur = offset_sample(cur, $urandom_range(1, SMALL_MAX));
                    else if (r < 90)
                        cur = offset_sample(cur, $urandom_range(SMALL_MAX + 1, 40));
                    else
                        cur = any_sample();
                end
            end
            if ($urandom_range(19) == 0)
                wait_drained();
            send_sample(cur, i == len - 1);
        end
    endtask

    initial
    begin
        int start;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        src_idle_pct = 20;
        dst_idle_pct = 51;

        // pass-through extremes
        write_mode(MODE_PASS);
        send_sample(SMP_MIN, 1'b0);
        send_sample(SMP_MAX, 1'b1);
        send_sample(0, 1'b0);
        send_sample(-1, 1'b1);
        wait_drained();
        write_mode(MODE_PACK);

        // single-sample waveform: raw value then an empty last word
        send_sample(5, 1'b1);
        // zero run, every small code, word overflow, raw zero, raw minimum,
        // raw after an empty word, lone zero on the last sample
        send_sample(100, 1'b0);
        send_sample(100, 1'b0);
        send_sample(100, 1'b0);
        send_sample(100, 1'b0);
        send_sample(100, 1'b0);
        send_sample(101, 1'b0);
        send_sample(100, 1'b0);
        send_sample(102, 1'b0);
        send_sample(100, 1'b0);
        send_sample(103, 1'b0);
        send_sample(100, 1'b0);
        send_sample(0, 1'b0);
        send_sample(SMP_MIN, 1'b0);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MAX, 1'b1);

        // mode switched while a zero is held back
        send_sample(50, 1'b0);
        send_sample(50, 1'b0);
        wait_drained();
        write_mode(MODE_PASS);
        send_sample(-7, 1'b0);
        wait_drained();
        write_mode(MODE_PACK);
        send_sample(50, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 51 : 0;
            dst_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 20 : 0;
            start = sent_count;
            while (sent_count - start < 80)
            begin
                if ($urandom_range(7) == 0)
                    wait_drained();
                send_waveform(($urandom_range(9) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12));
            end
            wait_drained();
            write_mode(MODE_PASS);
            for (int i = 0; i < 20; i++)
                send_sample(any_sample(), 1'($urandom_range(1)));
            wait_drained();
            write_mode(MODE_PACK);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/adhp_pkg.sv
rtl/adhp_front.sv
rtl/adhp_fifo.sv
rtl/adhp_back.sv
rtl/adc_delta_huffman_packer_core.sv
tb/sv/adc_delta_huffman_packer_core_checker.sv
tb/sv/adc_delta_huffman_packer_core_tb.sv
